### hw/rtl/gtq_pkg.sv
// Package for the team queue: sizes, codes and transaction types.
`default_nettype none
package gtq_pkg;

  localparam int TEAMS    = 1024;
  localparam int ELEMENTS = 1024;
  localparam int CAPACITY = 1024;

  localparam int ID_W   = 10;
  localparam int ELEM_W = $clog2(ELEMENTS);
  localparam int TEAM_W = $clog2(TEAMS);
  localparam int SLOT_W = $clog2(CAPACITY);
  localparam int FC_W   = $clog2(CAPACITY + 1);
  localparam int OC_W   = $clog2(TEAMS + 1);
  localparam int CLR_LEN = (ELEMENTS > TEAMS) ?
                           ((ELEMENTS > CAPACITY) ? ELEMENTS : CAPACITY) :
                           ((TEAMS > CAPACITY) ? TEAMS : CAPACITY);
  localparam int CLR_W  = $clog2(CLR_LEN);
  localparam int QDEPTH = 2;

  typedef enum logic [1:0] {
    OP_CLEAR   = 2'd0,
    OP_ASSIGN  = 2'd1,
    OP_ENQUEUE = 2'd2,
    OP_DEQUEUE = 2'd3
  } gtq_op_t;

  typedef enum logic [1:0] {
    STS_DONE  = 2'd0,
    STS_EMPTY = 2'd1,
    STS_FULL  = 2'd2,
    STS_VALID = 2'd3
  } gtq_status_t;

  typedef struct packed {
    logic [1:0]      req_type;
    logic [ID_W-1:0] element_id;
    logic [ID_W-1:0] team_id;
  } gtq_req_t;

  typedef struct packed {
    logic [ID_W-1:0] out_element;
    logic [1:0]      status;
  } gtq_res_t;

  typedef struct packed {
    gtq_op_t         op;
    logic [ID_W-1:0] element;
    logic [ID_W-1:0] team;
    logic            elem_ok;
    logic            assign_ok;
  } gtq_cmd_t;

  typedef enum logic [3:0] {
    ST_CLR, ST_IDLE, ST_ASG,
    ST_EQ1, ST_EQ2, ST_EQ3,
    ST_DQ1, ST_DQ2, ST_DQ3, ST_DQ4
  } gtq_state_t;

endpackage
`default_nettype wire

### hw/rtl/grouped_team_queue.sv
// Each operation runs its own back-end states; full/empty errors end in the first one.
// The back end's memory sequencer carries out one transaction at a time.
// A two-entry command queue lets requests be taken while the back end works.
// Reset and clear sweep the membership, waiting and free-slot memories.
// busy stays high during reset; the receiver cannot stall results.
`default_nettype none
module grouped_team_queue (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              start,
  input  wire gtq_pkg::gtq_req_t req,
  output logic                   busy,
  output logic                   done,
  output gtq_pkg::gtq_res_t      result
);
  import gtq_pkg::*;

  gtq_cmd_t cmd;
  logic     cmd_valid;
  logic     cmd_pop;

  gtq_front u_front (
    .clk, .rst, .start, .req, .busy,
    .cmd, .cmd_valid, .cmd_pop
  );

  gtq_back u_back (
    .clk, .rst, .cmd, .cmd_valid, .cmd_pop,
    .done, .result
  );
endmodule
`default_nettype wire

### hw/rtl/gtq_ram.sv
// Generic single-write, single-read RAM with registered read data.
`default_nettype none
module gtq_ram #(
  parameter int W = 8,
  parameter int D = 16
) (
  input  wire logic                 clk,
  input  wire logic                 we,
  input  wire logic [$clog2(D)-1:0] waddr,
  input  wire logic [W-1:0]         wdata,
  input  wire logic [$clog2(D)-1:0] raddr,
  output logic      [W-1:0]         rdata
);
  logic [W-1:0] mem [D];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule
`default_nettype wire

### hw/rtl/gtq_front.sv
// Front end: takes requests, classifies them and queues them for the back end.
`default_nettype none
module gtq_front (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              start,
  input  wire gtq_pkg::gtq_req_t req,
  output logic                   busy,
  output gtq_pkg::gtq_cmd_t      cmd,
  output logic                   cmd_valid,
  input  wire logic              cmd_pop
);
  import gtq_pkg::*;

  localparam int QP_W = $clog2(QDEPTH);

  gtq_cmd_t                queue [QDEPTH];
  logic     [QP_W-1:0]     wr_ptr;
  logic     [QP_W-1:0]     rd_ptr;
  logic     [QP_W:0]       count;
  gtq_cmd_t                cls;
  logic                    push;

  always_comb begin
    cls.op        = gtq_op_t'(req.req_type);
    cls.element   = req.element_id;
    cls.team      = req.team_id;
    cls.elem_ok   = 32'(req.element_id) < ELEMENTS;
    cls.assign_ok = (32'(req.element_id) < ELEMENTS) && (32'(req.team_id) < TEAMS);
  end

  assign busy      = rst || (32'(count) == QDEPTH);
  assign push      = start && !busy;
  assign cmd_valid = count != '0;
  assign cmd       = queue[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      queue[wr_ptr] <= cls;
    end
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (32'(wr_ptr) == QDEPTH - 1) ? '0 : wr_ptr + 1'b1;
      end
      if (cmd_pop) begin
        rd_ptr <= (32'(rd_ptr) == QDEPTH - 1) ? '0 : rd_ptr + 1'b1;
      end
      count <= count + (QP_W+1)'(push) - (QP_W+1)'(cmd_pop);
    end
  end
endmodule
`default_nettype wire

### hw/rtl/gtq_back.sv
// Back end: carries out queued commands on the linked-list memories.
`default_nettype none
module gtq_back (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire gtq_pkg::gtq_cmd_t cmd,
  input  wire logic              cmd_valid,
  output logic                   cmd_pop,
  output logic                   done,
  output gtq_pkg::gtq_res_t      result
);
  import gtq_pkg::*;

  gtq_state_t state, state_next;
  gtq_cmd_t   cur, cur_next;
  logic       clr_req, clr_req_next;
  logic [CLR_W-1:0]  idx, idx_next;
  logic [FC_W-1:0]   fc, fc_next;
  logic [OC_W-1:0]   oc, oc_next;
  logic [TEAM_W-1:0] rd_ptr, rd_ptr_next;
  logic [TEAM_W-1:0] wr_ptr, wr_ptr_next;
  logic [TEAM_W-1:0] t_reg, t_reg_next;
  logic [SLOT_W-1:0] s_reg, s_reg_next;
  logic              last, last_next;
  logic              done_next;
  gtq_res_t          result_next;

  // memory ports
  logic              mem_we, wait_we, hd_we, tl_we, se_we, sn_we, fr_we, or_we;
  logic [ELEM_W-1:0] mem_wa, mem_ra;
  logic [ID_W-1:0]   mem_wd, mem_rd;
  logic [TEAM_W-1:0] wait_wa, wait_ra, hd_wa, hd_ra, tl_wa, tl_ra, or_wa, or_ra;
  logic              wait_wd, wait_rd;
  logic [SLOT_W-1:0] hd_wd, hd_rd, tl_wd, tl_rd, sn_wa, sn_ra, sn_wd, sn_rd;
  logic [SLOT_W-1:0] se_wa, se_ra, fr_wa, fr_ra, fr_wd, fr_rd;
  logic [ID_W-1:0]   se_wd, se_rd;
  logic [TEAM_W-1:0] or_wd, or_rd;
  logic [TEAM_W-1:0] t_enq;

  gtq_ram #(.W(ID_W),   .D(ELEMENTS)) u_member (.clk, .we(mem_we), .waddr(mem_wa),
    .wdata(mem_wd), .raddr(mem_ra), .rdata(mem_rd));
  gtq_ram #(.W(1),      .D(TEAMS))    u_waiting (.clk, .we(wait_we), .waddr(wait_wa),
    .wdata(wait_wd), .raddr(wait_ra), .rdata(wait_rd));
  gtq_ram #(.W(SLOT_W), .D(TEAMS))    u_head (.clk, .we(hd_we), .waddr(hd_wa),
    .wdata(hd_wd), .raddr(hd_ra), .rdata(hd_rd));
  gtq_ram #(.W(SLOT_W), .D(TEAMS))    u_tail (.clk, .we(tl_we), .waddr(tl_wa),
    .wdata(tl_wd), .raddr(tl_ra), .rdata(tl_rd));
  gtq_ram #(.W(ID_W),   .D(CAPACITY)) u_slot_elem (.clk, .we(se_we), .waddr(se_wa),
    .wdata(se_wd), .raddr(se_ra), .rdata(se_rd));
  gtq_ram #(.W(SLOT_W), .D(CAPACITY)) u_slot_next (.clk, .we(sn_we), .waddr(sn_wa),
    .wdata(sn_wd), .raddr(sn_ra), .rdata(sn_rd));
  gtq_ram #(.W(SLOT_W), .D(CAPACITY)) u_free (.clk, .we(fr_we), .waddr(fr_wa),
    .wdata(fr_wd), .raddr(fr_ra), .rdata(fr_rd));
  gtq_ram #(.W(TEAM_W), .D(TEAMS))    u_order (.clk, .we(or_we), .waddr(or_wa),
    .wdata(or_wd), .raddr(or_ra), .rdata(or_rd));

  assign t_enq = (!cur.elem_ok || 32'(mem_rd) >= TEAMS) ? '0 : TEAM_W'(mem_rd);

  always_comb begin
    state_next = state;
    unique case (state)
      ST_CLR:  if (32'(idx) == CLR_LEN - 1) state_next = ST_IDLE;
      ST_IDLE: begin
        if (cmd_valid) begin
          unique case (cmd.op)
            OP_CLEAR:   state_next = ST_CLR;
            OP_ASSIGN:  state_next = ST_ASG;
            OP_ENQUEUE: state_next = ST_EQ1;
            OP_DEQUEUE: state_next = ST_DQ1;
            default:    state_next = ST_IDLE;
          endcase
        end
      end
      ST_ASG:  state_next = ST_IDLE;
      ST_EQ1:  state_next = (fc == '0) ? ST_IDLE : ST_EQ2;
      ST_EQ2:  state_next = ST_EQ3;
      ST_EQ3:  state_next = ST_IDLE;
      ST_DQ1:  state_next = (oc == '0) ? ST_IDLE : ST_DQ2;
      ST_DQ2:  state_next = ST_DQ3;
      ST_DQ3:  state_next = ST_DQ4;
      ST_DQ4:  state_next = ST_IDLE;
      default: state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd_pop      = 1'b0;
    cur_next     = cur;
    clr_req_next = clr_req;
    idx_next     = idx;
    fc_next      = fc;
    oc_next      = oc;
    rd_ptr_next  = rd_ptr;
    wr_ptr_next  = wr_ptr;
    t_reg_next   = t_reg;
    s_reg_next   = s_reg;
    last_next    = last;
    done_next    = 1'b0;
    result_next  = '{out_element: '0, status: STS_DONE};

    mem_we = 1'b0; mem_wa = ELEM_W'(cur.element); mem_wd = cur.team;
    mem_ra = ELEM_W'(cur.element);
    wait_we = 1'b0; wait_wa = t_reg; wait_wd = 1'b0; wait_ra = t_enq;
    hd_we = 1'b0; hd_wa = t_reg; hd_wd = s_reg; hd_ra = or_rd;
    tl_we = 1'b0; tl_wa = t_reg; tl_wd = s_reg;
    tl_ra = (state == ST_DQ2) ? or_rd : t_enq;
    se_we = 1'b0; se_wa = fr_rd; se_wd = cur.element; se_ra = hd_rd;
    sn_we = 1'b0; sn_wa = fr_rd; sn_wd = fr_rd; sn_ra = hd_rd;
    fr_we = 1'b0; fr_wa = SLOT_W'(fc); fr_wd = s_reg; fr_ra = SLOT_W'(fc - 1'b1);
    or_we = 1'b0; or_wa = wr_ptr; or_wd = t_reg; or_ra = rd_ptr;

    unique case (state)
      ST_CLR: begin
        mem_we  = 32'(idx) < ELEMENTS;
        mem_wa  = ELEM_W'(idx);
        mem_wd  = '0;
        wait_we = 32'(idx) < TEAMS;
        wait_wa = TEAM_W'(idx);
        fr_we   = 32'(idx) < CAPACITY;
        fr_wa   = SLOT_W'(idx);
        fr_wd   = SLOT_W'(CAPACITY - 1 - int'(idx));
        idx_next = idx + 1'b1;
        if (32'(idx) == CLR_LEN - 1) begin
          idx_next    = '0;
          fc_next     = FC_W'(CAPACITY);
          oc_next     = '0;
          rd_ptr_next = '0;
          wr_ptr_next = '0;
          done_next   = clr_req;
          clr_req_next = 1'b0;
        end
      end
      ST_IDLE: begin
        if (cmd_valid) begin
          cmd_pop      = 1'b1;
          cur_next     = cmd;
          clr_req_next = cmd.op == OP_CLEAR;
        end
      end
      ST_ASG: begin
        mem_we    = cur.assign_ok;
        done_next = 1'b1;
      end
      ST_EQ1: begin
        if (fc == '0) begin
          done_next          = 1'b1;
          result_next.status = STS_FULL;
        end
      end
      ST_EQ2: begin
        t_reg_next = t_enq;
        s_reg_next = fr_rd;
        se_we      = 1'b1;
        sn_we      = 1'b1;
      end
      ST_EQ3: begin
        fc_next   = fc - 1'b1;
        done_next = 1'b1;
        tl_we     = 1'b1;
        if (!wait_rd) begin
          wait_we     = 1'b1;
          wait_wd     = 1'b1;
          hd_we       = 1'b1;
          or_we       = 1'b1;
          wr_ptr_next = (32'(wr_ptr) == TEAMS - 1) ? '0 : wr_ptr + 1'b1;
          oc_next     = oc + 1'b1;
        end else begin
          sn_we = 1'b1;
          sn_wa = tl_rd;
          sn_wd = s_reg;
        end
      end
      ST_DQ1: begin
        if (oc == '0) begin
          done_next          = 1'b1;
          result_next.status = STS_EMPTY;
        end
      end
      ST_DQ2: begin
        t_reg_next = or_rd;
      end
      ST_DQ3: begin
        s_reg_next = hd_rd;
        last_next  = hd_rd == tl_rd;
      end
      ST_DQ4: begin
        done_next               = 1'b1;
        result_next.status      = STS_VALID;
        result_next.out_element = se_rd;
        if (32'(fc) < CAPACITY) begin
          fr_we   = 1'b1;
          fc_next = fc + 1'b1;
        end
        if (last) begin
          wait_we     = 1'b1;
          rd_ptr_next = (32'(rd_ptr) == TEAMS - 1) ? '0 : rd_ptr + 1'b1;
          oc_next     = oc - 1'b1;
        end else begin
          hd_we = 1'b1;
          hd_wd = sn_rd;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    cur    <= cur_next;
    t_reg  <= t_reg_next;
    s_reg  <= s_reg_next;
    last   <= last_next;
    result <= result_next;
    if (rst) begin
      state   <= ST_CLR;
      clr_req <= 1'b0;
      idx     <= '0;
      fc      <= FC_W'(CAPACITY);
      oc      <= '0;
      rd_ptr  <= '0;
      wr_ptr  <= '0;
      done    <= 1'b0;
    end else begin
      state   <= state_next;
      clr_req <= clr_req_next;
      idx     <= idx_next;
      fc      <= fc_next;
      oc      <= oc_next;
      rd_ptr  <= rd_ptr_next;
      wr_ptr  <= wr_ptr_next;
      done    <= done_next;
    end
  end

  a_fc_range: assert property (@(posedge clk) disable iff (rst) 32'(fc) <= CAPACITY)
    else $error("free count out of range");
  a_oc_range: assert property (@(posedge clk) disable iff (rst) 32'(oc) <= TEAMS)
    else $error("order count out of range");
  a_pop_idle: assert property (@(posedge clk) disable iff (rst)
      cmd_pop |-> (state == ST_IDLE) && cmd_valid)
    else $error("command popped outside idle");
  a_deq_res: assert property (@(posedge clk) disable iff (rst)
      (state == ST_DQ4) |=> done && result.status == STS_VALID)
    else $error("dequeue gave no valid result");
endmodule
`default_nettype wire

### sim/grouped_team_queue_test.sv
// Testbench for the team queue: directed table, random traffic and a fill to capacity, checked by a predictor.
`timescale 1ns / 1ps
`default_nettype none
module grouped_team_queue_test;
  import gtq_pkg::*;

  localparam int IDLE_LIMIT = 20000;
  localparam int RANDOM_ITEMS = 140;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic start = 1'b0;
  gtq_req_t req = '0;
  logic busy;
  logic done;
  gtq_res_t result;

  grouped_team_queue dut (
    .clk(clk), .rst(rst), .start(start), .req(req),
    .busy(busy), .done(done), .result(result)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  logic [TEAM_W-1:0] team_of [ELEMENTS];
  logic [ELEM_W-1:0] members [TEAMS][$];
  logic [TEAM_W-1:0] team_order [$];
  int stored;

  gtq_res_t pending_results [$];
  gtq_res_t last_res = '0;
  int errors = 0;
  int accepted = 0;
  int results_seen = 0;
  int idle_cycles = 0;
  int n_valid = 0, n_empty = 0, n_full = 0;
  bit quiet = 1'b0;

  function automatic void wipe_queue();
    foreach (team_of[i]) team_of[i] = '0;
    foreach (members[i]) members[i].delete();
    team_order.delete();
    stored = 0;
  endfunction

  function automatic gtq_res_t queue_step(gtq_req_t r);
    gtq_res_t o;
    logic [TEAM_W-1:0] t;
    o = '0;
    o.status = STS_DONE;
    case (gtq_op_t'(r.req_type))
      OP_CLEAR: wipe_queue();
      OP_ASSIGN: team_of[r.element_id] = r.team_id;
      OP_ENQUEUE: begin
        if (stored >= CAPACITY) begin
          o.status = STS_FULL;
        end else begin
          t = team_of[r.element_id];
          if (members[t].size() == 0) team_order.insert(team_order.size(), t);
          members[t].insert(members[t].size(), r.element_id);
          stored++;
        end
      end
      OP_DEQUEUE: begin
        if (team_order.size() == 0) begin
          o.status = STS_EMPTY;
        end else begin
          t = team_order[0];
          o.out_element = members[t].pop_front();
          o.status = STS_VALID;
          stored--;
          if (members[t].size() == 0) void'(team_order.pop_front());
        end
      end
    endcase
    return o;
  endfunction

  task automatic send(gtq_req_t r);
    if (!quiet && $urandom_range(99) < 18) begin
      start <= 1'b0;
      repeat ($urandom_range(4, 1)) @(negedge clk);
    end
    start <= 1'b1;
    req <= r;
    @(posedge clk);
    while (busy) @(posedge clk);
    @(negedge clk);
  endtask

  // expectation queued at the accepting edge keeps order with results
  always @(posedge clk) begin
    if (!rst && start && !busy) begin
      pending_results.insert(pending_results.size(), queue_step(req));
      accepted++;
    end
  end

  always @(posedge clk) begin
    gtq_res_t exp_res;
    if (!rst && done) begin
      results_seen++;
      last_res = result;
      if (pending_results.size() == 0) begin
        $display("%0t: unexpected result %h", $time, result);
        errors++;
      end else begin
        exp_res = pending_results.pop_front();
        if (result.status != exp_res.status) begin
          $display("%0t: status expected %0d actual %0d", $time, exp_res.status,
                   result.status);
          errors++;
        end
        if (result.out_element != exp_res.out_element) begin
          $display("%0t: element expected %0d actual %0d", $time,
                   exp_res.out_element, result.out_element);
          errors++;
        end
        case (gtq_status_t'(result.status))
          STS_VALID: n_valid++;
          STS_EMPTY: n_empty++;
          STS_FULL:  n_full++;
          default: ;
        endcase
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (start && !busy) || done) idle_cycles = 0;
    else idle_cycles++;
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("%0t: timeout, %0d results outstanding", $time, pending_results.size());
      $display("RESULT: ERROR");
      $finish;
    end
  end

  typedef struct {
    gtq_op_t op;
    int unsigned element;
    int unsigned team;
    bit typed;
    gtq_res_t want;
  } stim_row_t;

  stim_row_t directed [] = '{
    '{OP_DEQUEUE, 0, 0, 1, '{10'd0, STS_EMPTY}},
    '{OP_ENQUEUE, 1023, 1023, 1, '{10'd0, STS_DONE}},
    '{OP_ASSIGN, 1023, 1023, 1, '{10'd0, STS_DONE}},
    '{OP_ASSIGN, 5, 1023, 0, '{10'd0, STS_DONE}},
    '{OP_ASSIGN, 7, 3, 0, '{10'd0, STS_DONE}},
    '{OP_ENQUEUE, 5, 0, 0, '{10'd0, STS_DONE}},
    '{OP_ENQUEUE, 7, 0, 0, '{10'd0, STS_DONE}},
    '{OP_ENQUEUE, 1023, 0, 0, '{10'd0, STS_DONE}},
    '{OP_ENQUEUE, 0, 0, 0, '{10'd0, STS_DONE}},
    '{OP_ENQUEUE, 1005, 0, 0, '{10'd0, STS_DONE}},
    '{OP_DEQUEUE, 0, 0, 1, '{10'd1023, STS_VALID}},
    '{OP_DEQUEUE, 0, 0, 0, '{10'd0, STS_DONE}},
    '{OP_DEQUEUE, 0, 0, 0, '{10'd0, STS_DONE}},
    '{OP_DEQUEUE, 0, 0, 0, '{10'd0, STS_DONE}},
    '{OP_DEQUEUE, 0, 0, 0, '{10'd0, STS_DONE}},
    '{OP_DEQUEUE, 0, 0, 0, '{10'd0, STS_DONE}},
    '{OP_DEQUEUE, 0, 0, 1, '{10'd0, STS_EMPTY}},
    '{OP_ENQUEUE, 7, 0, 0, '{10'd0, STS_DONE}},
    '{OP_CLEAR, 1023, 1023, 1, '{10'd0, STS_DONE}},
    '{OP_DEQUEUE, 0, 0, 1, '{10'd0, STS_EMPTY}},
    '{OP_ENQUEUE, 7, 0, 0, '{10'd0, STS_DONE}},
    '{OP_DEQUEUE, 0, 0, 1, '{10'd7, STS_VALID}}
  };

  function automatic gtq_req_t make_req(gtq_op_t op, int unsigned e, int unsigned t);
    gtq_req_t r;
    r.req_type = op;
    r.element_id = e[ID_W-1:0];
    r.team_id = t[ID_W-1:0];
    return r;
  endfunction

  task automatic wait_drained();
    start <= 1'b0;
    while (pending_results.size() != 0) @(negedge clk);
    repeat (8) @(negedge clk);
  endtask

  task automatic fill_storage();
    quiet = 1'b1;
    for (int i = 0; i < CAPACITY; i++)
      send(make_req(OP_ENQUEUE, $urandom_range(1023), 0));
    send(make_req(OP_ENQUEUE, $urandom_range(1023), 0));
    send(make_req(OP_ENQUEUE, 1023, 1023));
    quiet = 1'b0;
  endtask

  task automatic random_phase(int count);
    int unsigned pick;
    gtq_op_t op;
    for (int i = 0; i < count; i++) begin
      quiet = (i >= count / 3) && (i < count / 2);
      pick = $urandom_range(99);
      if (pick < 1) op = OP_CLEAR;
      else if (pick < 20) op = OP_ASSIGN;
      else if (pick < 62) op = OP_ENQUEUE;
      else op = OP_DEQUEUE;
      // mostly a small set of elements and teams so teams interleave
      if ($urandom_range(9) == 0)
        send(make_req(op, $urandom, $urandom));
      else
        send(make_req(op, $urandom_range(31), $urandom_range(7)));
    end
    quiet = 1'b0;
  endtask

  initial begin
    wipe_queue();
    repeat (8) @(negedge clk);
    rst <= 1'b0;

    foreach (directed[i]) begin
      send(make_req(directed[i].op, directed[i].element, directed[i].team));
      if (directed[i].typed) begin
        wait_drained();
        if (last_res != directed[i].want) begin
          $display("%0t: table row %0d expected %h actual %h", $time, i,
                   directed[i].want, last_res);
          errors++;
        end
      end
    end
    wait_drained();

    random_phase(RANDOM_ITEMS / 2);
    // hold off until everything is back
    wait_drained();
    fill_storage();
    for (int i = 0; i < 40; i++) send(make_req(OP_DEQUEUE, 0, 0));
    random_phase(RANDOM_ITEMS / 2);

    wait_drained();
    repeat (40) @(negedge clk);
    $display("Covered %0d requests, %0d results: %0d dequeued, %0d empty, %0d full.",
             accepted, results_seen, n_valid, n_empty, n_full);
    if (errors == 0 && pending_results.size() == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
`default_nettype wire

### filelist.f
hw/rtl/gtq_pkg.sv
hw/rtl/gtq_ram.sv
hw/rtl/gtq_front.sv
hw/rtl/gtq_back.sv
hw/rtl/grouped_team_queue.sv
sim/grouped_team_queue_test.sv
